// ===== src/bvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvp_pkg: battery voltage to percent, shared constants and table functions
// Open-circuit-voltage table of a single LiPo cell and per-segment helpers.
// ----------------------------------------------------------------------------
package bvp_pkg;

  localparam int OCV_POINTS = 23;
  localparam int SEG_COUNT  = OCV_POINTS - 1;
  localparam int MAX_DP     = 6;    // largest percent step between two points

  localparam logic [15:0] GAIN_RESET = 16'd8192;  // 2.0 in Q4.12
  localparam logic [15:0] MV_FULL    = 16'd4200;
  localparam logic [15:0] MV_EMPTY   = 16'd3270;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [6:0]  PCT_EMPTY  = 7'd0;

  typedef logic [12:0] mv_tbl_t  [OCV_POINTS];
  typedef logic [6:0]  pct_tbl_t [OCV_POINTS];

  // Table runs from full to empty
  localparam mv_tbl_t OCV_MV = '{
    13'd4200, 13'd4170, 13'd4140, 13'd4110, 13'd4080, 13'd4050, 13'd4020, 13'd3980,
    13'd3950, 13'd3910, 13'd3870, 13'd3830, 13'd3790, 13'd3750, 13'd3710, 13'd3670,
    13'd3610, 13'd3550, 13'd3490, 13'd3420, 13'd3360, 13'd3300, 13'd3270
  };
  localparam pct_tbl_t OCV_PCT = '{
    7'd100, 7'd97, 7'd94, 7'd91, 7'd87, 7'd83, 7'd79, 7'd74,
    7'd70,  7'd65, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd29,  7'd23, 7'd17, 7'd12, 7'd7,  7'd3,  7'd0
  };

  // Voltage width of segment i (upper point i, lower point i+1)
  function automatic logic [6:0] seg_span(input logic [4:0] i);
    seg_span = 7'(OCV_MV[i] - OCV_MV[i + 5'd1]);
  endfunction

  // Percent rise across segment i
  function automatic logic [2:0] seg_dp(input logic [4:0] i);
    seg_dp = 3'(OCV_PCT[i] - OCV_PCT[i + 5'd1]);
  endfunction

  // Rounding threshold for step k of segment i: (2k-1)*span
  function automatic logic [9:0] seg_thr(input logic [4:0] i, input logic [2:0] k);
    seg_thr = 10'(({6'b0, k, 1'b0} - 10'd1) * {3'b0, seg_span(i)});
  endfunction

endpackage
`default_nettype wire

// ===== src/battery_voltage_to_percent.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_to_percent: LiPo cell voltage and state-of-charge estimator
//
// Usage:
//   A request carries four ADC readings (sample_0..3, mV). It is taken on a
//   rising edge with start high and busy low; busy is always low, so a new
//   request may be issued every cycle.
//   The readings are summed, scaled by divider_gain (Q4.12, written through
//   divider_gain_we / divider_gain_wdata) and divided by 16384, giving
//   battery_mv. The charge is interpolated over a 23-point OCV table and
//   rounded half up, clamped to 100 % at 4200 mV and 0 % at 3270 mV.
//   Each request yields one result: done stays high for one cycle with
//   charge_percent and battery_mv valid; done and both result fields are
//   registered together on the same clock edge, in the last stage.
//   Throughput is one request per cycle through a six-stage pipeline:
//   sum, multiply, threshold compare, segment encode, segment multiply,
//   rounding compare.
//   Reset clears every pipeline valid bit and loads the gain with 2.0.
//   The receiver cannot stall: results are presented once and not held.
// ----------------------------------------------------------------------------
module battery_voltage_to_percent
  import bvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [11:0] sample_0,
  input  wire logic [11:0] sample_1,
  input  wire logic [11:0] sample_2,
  input  wire logic [11:0] sample_3,
  input  wire logic        divider_gain_we,
  input  wire logic [15:0] divider_gain_wdata,
  output      logic        done,
  output      logic [6:0]  charge_percent,
  output      logic [15:0] battery_mv
);

  logic              accept;
  logic [15:0]       divider_gain;

  // stage registers
  logic              s1_valid;
  logic [13:0]       s1_sum;
  logic              s2_valid;
  logic [15:0]       s2_mv;
  logic              s3_valid;
  logic [15:0]       s3_mv;
  logic [SEG_COUNT-1:0] s3_below;
  logic              s3_full;
  logic              s3_empty;
  logic              s4_valid;
  logic [15:0]       s4_mv;
  logic [4:0]        s4_idx;
  logic [6:0]        s4_diff;
  logic              s4_full;
  logic              s4_empty;
  logic              s5_valid;
  logic [15:0]       s5_mv;
  logic [4:0]        s5_idx;
  logic [9:0]        s5_prod;
  logic              s5_full;
  logic              s5_empty;

  // combinational
  logic [29:0]       s2_product;
  logic [SEG_COUNT-1:0] s3_below_next;
  logic [4:0]        s4_idx_next;
  logic [15:0]       s4_diff_wide;
  logic [2:0]        s6_steps;
  logic [6:0]        s6_pct;
  logic [9:0]        s6_twice;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain <= GAIN_RESET;
    end else if (divider_gain_we) begin
      divider_gain <= divider_gain_wdata;
    end
  end

  // Stage 1: sum of the four readings
  always_ff @(posedge clk) begin
    s1_sum <= 14'(sample_0) + 14'(sample_1) + 14'(sample_2) + 14'(sample_3);
  end

  // Stage 2: gain and average, floor of sum*gain/16384
  assign s2_product = 30'(s1_sum) * 30'(divider_gain);

  always_ff @(posedge clk) begin
    s2_mv <= s2_product[29:14];
  end

  // Stage 3: compare against every table point but the last, and the clamp limits
  always_comb begin
    for (int k = 0; k < SEG_COUNT; k++) begin
      s3_below_next[k] = s2_mv < 16'(OCV_MV[k]);
    end
  end

  always_ff @(posedge clk) begin
    s3_mv    <= s2_mv;
    s3_below <= s3_below_next;
    s3_full  <= s2_mv >= MV_FULL;
    s3_empty <= s2_mv <= MV_EMPTY;
  end

  // Stage 4: segment index is the last point still above the voltage
  always_comb begin
    s4_idx_next = '0;
    for (int k = 0; k < SEG_COUNT; k++) begin
      if (s3_below[k]) begin
        s4_idx_next = 5'(k);
      end
    end
  end

  assign s4_diff_wide = s3_mv - 16'(OCV_MV[s4_idx_next + 5'd1]);

  always_ff @(posedge clk) begin
    s4_mv    <= s3_mv;
    s4_idx   <= s4_idx_next;
    s4_diff  <= s4_diff_wide[6:0];
    s4_full  <= s3_full;
    s4_empty <= s3_empty;
  end

  // Stage 5: offset times percent rise of the segment
  always_ff @(posedge clk) begin
    s5_mv    <= s4_mv;
    s5_idx   <= s4_idx;
    s5_prod  <= 10'(s4_diff) * 10'(seg_dp(s4_idx));
    s5_full  <= s4_full;
    s5_empty <= s4_empty;
  end

  // Stage 6: rounded quotient by counting crossed thresholds
  assign s6_twice = {s5_prod[8:0], 1'b0};

  always_comb begin
    s6_steps = '0;
    for (int k = 1; k <= MAX_DP; k++) begin
      if (s6_twice >= seg_thr(s5_idx, 3'(k))) begin
        s6_steps = s6_steps + 3'd1;
      end
    end
  end

  always_comb begin
    priority if (s5_full) begin
      s6_pct = PCT_FULL;
    end else if (s5_empty) begin
      s6_pct = PCT_EMPTY;
    end else begin
      s6_pct = OCV_PCT[s5_idx + 5'd1] + 7'(s6_steps);
    end
  end

  always_ff @(posedge clk) begin
    charge_percent <= s6_pct;
    battery_mv     <= s5_mv;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      done     <= s5_valid;
    end
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("request did not produce a result after six cycles");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> charge_percent <= PCT_FULL)
    else $error("charge above full scale");

  a_full: assert property (@(posedge clk) disable iff (rst)
    done && (battery_mv >= MV_FULL) |-> charge_percent == PCT_FULL)
    else $error("full cell not reported as full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    done && (battery_mv <= MV_EMPTY) |-> charge_percent == PCT_EMPTY)
    else $error("empty cell not reported as empty");

endmodule
`default_nettype wire

// ===== verif/bvp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvp_checker: result checker for battery_voltage_to_percent
// Watches the request and result channels and the gain register writes,
// predicts charge and battery voltage for each request, and compares every
// result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bvp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] sample_0,
  input  logic [11:0] sample_1,
  input  logic [11:0] sample_2,
  input  logic [11:0] sample_3,
  input  logic        divider_gain_we,
  input  logic [15:0] divider_gain_wdata,
  input  logic        done,
  input  logic [6:0]  charge_percent,
  input  logic [15:0] battery_mv,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic [6:0]  pct;
    logic [15:0] mv;
  } soc_result_t;

  // Open-circuit-voltage curve, full to empty
  int ocv_point_mv [23] = '{
    4200, 4170, 4140, 4110, 4080, 4050, 4020, 3980, 3950, 3910, 3870, 3830,
    3790, 3750, 3710, 3670, 3610, 3550, 3490, 3420, 3360, 3300, 3270
  };
  int ocv_point_pct [23] = '{
    100, 97, 94, 91, 87, 83, 79, 74, 70, 65, 60, 55,
    50, 45, 40, 35, 29, 23, 17, 12, 7, 3, 0
  };

  logic [15:0] gain_shadow;
  soc_result_t soc_expected_q[$];

  // Piecewise-linear charge lookup, rounding half up inside a segment
  function automatic int charge_at(input int mv);
    int span;
    int dp;
    int num;
    if (mv >= ocv_point_mv[0]) return ocv_point_pct[0];
    if (mv <= ocv_point_mv[22]) return ocv_point_pct[22];
    for (int i = 0; i < 22; i++) begin
      if (mv >= ocv_point_mv[i + 1]) begin
        span = ocv_point_mv[i] - ocv_point_mv[i + 1];
        dp   = ocv_point_pct[i] - ocv_point_pct[i + 1];
        num  = 2 * (mv - ocv_point_mv[i + 1]) * dp + span;
        return ocv_point_pct[i + 1] + num / (2 * span);
      end
    end
    return 0;
  endfunction

  function automatic soc_result_t predict_soc(input logic [11:0] s0, input logic [11:0] s1,
                                              input logic [11:0] s2, input logic [11:0] s3,
                                              input logic [15:0] gain);
    logic [13:0] sum;
    logic [29:0] scaled;
    soc_result_t r;
    sum    = 14'(s0) + 14'(s1) + 14'(s2) + 14'(s3);
    scaled = 30'(sum) * 30'(gain);
    r.mv   = scaled[29:14];
    r.pct  = 7'(charge_at(int'(r.mv)));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Track requests, gain writes and results on each rising edge
  always @(posedge clk) begin
    soc_result_t want;
    if (rst) begin
      gain_shadow = 16'd8192;
      soc_expected_q.delete();
    end else begin
      if (start && !busy)
        soc_expected_q.push_back(predict_soc(sample_0, sample_1, sample_2, sample_3,
                                             gain_shadow));
      if (divider_gain_we)
        gain_shadow = divider_gain_wdata;
      if (done) begin
        if (soc_expected_q.size() == 0) begin
          report_mismatch("result with no request pending", int'(battery_mv), -1);
        end else begin
          want = soc_expected_q.pop_front();
          if (charge_percent !== want.pct)
            report_mismatch("charge_percent", int'(charge_percent), int'(want.pct));
          if (battery_mv !== want.mv)
            report_mismatch("battery_mv", int'(battery_mv), int'(want.mv));
        end
      end
    end
    pending_count <= soc_expected_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for battery_voltage_to_percent
// Drives directed and random ADC reading requests through several divider
// gain settings and sender idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASES         = 7;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] sample_0 = '0;
  logic [11:0] sample_1 = '0;
  logic [11:0] sample_2 = '0;
  logic [11:0] sample_3 = '0;
  logic        divider_gain_we = 1'b0;
  logic [15:0] divider_gain_wdata = '0;
  logic        done;
  logic [6:0]  charge_percent;
  logic [15:0] battery_mv;

  int          error_count;
  int          pending_count;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  logic [15:0] cur_gain = 16'd8192;

  always #5 clk = ~clk;

  battery_voltage_to_percent u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .sample_0           (sample_0),
    .sample_1           (sample_1),
    .sample_2           (sample_2),
    .sample_3           (sample_3),
    .divider_gain_we    (divider_gain_we),
    .divider_gain_wdata (divider_gain_wdata),
    .done               (done),
    .charge_percent     (charge_percent),
    .battery_mv         (battery_mv)
  );

  bvp_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .sample_0           (sample_0),
    .sample_1           (sample_1),
    .sample_2           (sample_2),
    .sample_3           (sample_3),
    .divider_gain_we    (divider_gain_we),
    .divider_gain_wdata (divider_gain_wdata),
    .done               (done),
    .charge_percent     (charge_percent),
    .battery_mv         (battery_mv),
    .error_count        (error_count),
    .pending_count      (pending_count)
  );

  // Watchdog: too long with no request taken and no result seen
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one request, hold it until taken, then maybe go idle for a while
  task automatic send_reading(input logic [11:0] s0, input logic [11:0] s1,
                              input logic [11:0] s2, input logic [11:0] s3);
    int gap;
    @(negedge clk);
    start    <= 1'b1;
    sample_0 <= s0;
    sample_1 <= s1;
    sample_2 <= s2;
    sample_3 <= s3;
    do @(posedge clk); while (busy);
    if ($urandom_range(99, 0) < idle_pct) begin
      gap = $urandom_range(5, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Split a reading sum randomly over the four samples
  task automatic send_sum(input int sum);
    int rem;
    int lo;
    int hi;
    logic [11:0] part [4];
    rem = sum;
    for (int k = 0; k < 4; k++) begin
      lo = rem - (3 - k) * 4095;
      if (lo < 0) lo = 0;
      hi = (rem > 4095) ? 4095 : rem;
      part[k] = 12'($urandom_range(hi, lo));
      rem -= part[k];
    end
    send_reading(part[0], part[1], part[2], part[3]);
  endtask

  // Aim a request at a battery voltage under the current gain
  task automatic send_voltage(input int mv);
    longint need;
    need = (longint'(mv) * 16384 + cur_gain - 1) / cur_gain;
    if (need > 16380) need = 16380;
    send_sum(int'(need));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic write_gain(input logic [15:0] g);
    @(negedge clk);
    divider_gain_we    <= 1'b1;
    divider_gain_wdata <= g;
    @(negedge clk);
    divider_gain_we    <= 1'b0;
    cur_gain = g;
  endtask

  initial begin
    int gain_plan [PHASES];
    int idle_plan [3];
    int directed_mv [16];
    gain_plan   = '{8192, 0, 65535, 4096, 12288, -1, 8192};
    idle_plan   = '{0, 68, 34};
    directed_mv = '{4200, 4199, 4201, 4170, 3270, 3271, 3269, 3300,
                    3275, 3274, 3794, 3793, 3950, 3670, 3985, 3500};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed requests at reset gain: field extremes, table points, clamps,
    // exact half-step rounding
    send_reading(12'h000, 12'h000, 12'h000, 12'h000);
    send_reading(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_reading(12'hAAA, 12'h555, 12'hAAA, 12'h555);
    send_reading(12'h555, 12'hAAA, 12'h555, 12'hAAA);
    foreach (directed_mv[i])
      send_voltage(directed_mv[i]);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Gain changes only with the pipeline empty; phase 0 keeps the reset value
      if (ph != 0) begin
        repeat (8) @(negedge clk);
        write_gain((gain_plan[ph] < 0) ? 16'($urandom) : 16'(gain_plan[ph]));
      end
      idle_pct = idle_plan[ph % 3];
      // Zero gain: every reading, including full scale, maps to 0 mV
      if (cur_gain == 0)
        send_reading(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (cur_gain != 0 && $urandom_range(3, 0) != 0)
          send_voltage($urandom_range(4300, 3200));
        else
          send_reading(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
